/* hw/rtl/zncc_pkg.sv */
// Shared types and constants for the ZNCC score unit.
package zncc_pkg;

    localparam int unsigned COUNT_MAX = 255;
    localparam int unsigned MUL_AW    = 112;
    localparam int unsigned MUL_BW    = 40;
    localparam logic [3:0]  Q_MSB     = 4'd14;

    typedef enum logic [3:0] {
        OP_N_SRR,
        OP_SR_SR,
        OP_N_SCC,
        OP_SC_SC,
        OP_N_SRC,
        OP_SR_SC,
        OP_VR_VC,
        OP_COV_COV,
        OP_P_T,
        OP_X_T
    } mul_op_t;

    typedef struct packed {
        logic       clear;
        logic       q_clear;
        logic       mul_start;
        mul_op_t    op;
        logic [3:0] bit_idx;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic last_done;
        logic mul_done;
        logic flat;
        logic cand_over;
        logic out_free;
    } dp_status_t;

endpackage

/* hw/rtl/zncc_ifs.sv */
// Valid/ready channel interfaces for pixel items and score items.
interface zncc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ref_pixel;
    logic [7:0] cur_top_left;
    logic [7:0] cur_top_right;
    logic [7:0] cur_bottom_left;
    logic [7:0] cur_bottom_right;
    logic [7:0] frac_x;
    logic [7:0] frac_y;
    logic       last;

    modport source (output valid, ref_pixel, cur_top_left, cur_top_right, cur_bottom_left,
                    cur_bottom_right, frac_x, frac_y, last, input ready);
    modport sink   (input valid, ref_pixel, cur_top_left, cur_top_right, cur_bottom_left,
                    cur_bottom_right, frac_x, frac_y, last, output ready);
endinterface

interface zncc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] score;
    logic               flat_window;

    modport source (output valid, score, flat_window, input ready);
    modport sink   (input valid, score, flat_window, output ready);
endinterface

/* hw/rtl/zncc_interp.sv */
// Two-stage bilinear interpolation of the current pixel to 8.8 fixed point.
module zncc_interp #(
    parameter int FRAC_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [7:0]  ref_pixel,
    input  logic [7:0]  cur_top_left,
    input  logic [7:0]  cur_top_right,
    input  logic [7:0]  cur_bottom_left,
    input  logic [7:0]  cur_bottom_right,
    input  logic [7:0]  frac_x,
    input  logic [7:0]  frac_y,
    input  logic        in_last,
    output logic        c_valid,
    output logic [15:0] c_value,
    output logic [7:0]  c_ref,
    output logic        c_last
);
    localparam int WW = 2 * FRAC_BITS + 2;
    localparam int AW = 2 * FRAC_BITS + 10;
    localparam int SH = 2 * FRAC_BITS - 8;
    localparam logic [AW-1:0] HALF = (SH == 0) ? AW'(0) : AW'(1) << (SH - 1);
    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

    logic [11:0]          fx_w, fy_w;
    logic [FRAC_BITS:0]   fx, fy, gx, gy;
    logic [WW-1:0]        w_tl, w_tr, w_bl, w_br;
    logic [AW-1:0]        acc, acc_shift;

    logic                 s1_valid_reg, s1_last_reg;
    logic [7:0]           s1_ref_reg, s1_tl_reg, s1_tr_reg, s1_bl_reg, s1_br_reg;
    logic [WW-1:0]        s1_wtl_reg, s1_wtr_reg, s1_wbl_reg, s1_wbr_reg;
    logic                 s2_valid_reg, s2_last_reg;
    logic [7:0]           s2_ref_reg;
    logic [15:0]          s2_c_reg;

    // Scale the 8-bit offsets to FRAC_BITS fractional bits.
    assign fx_w = {frac_x, 4'b0000} >> (12 - FRAC_BITS);
    assign fy_w = {frac_y, 4'b0000} >> (12 - FRAC_BITS);
    assign fx   = {1'b0, fx_w[FRAC_BITS-1:0]};
    assign fy   = {1'b0, fy_w[FRAC_BITS-1:0]};
    assign gx   = ONE - fx;
    assign gy   = ONE - fy;

    assign w_tl = WW'(gx) * WW'(gy);
    assign w_tr = WW'(fx) * WW'(gy);
    assign w_bl = WW'(gx) * WW'(fy);
    assign w_br = WW'(fx) * WW'(fy);

    assign acc = AW'(s1_tl_reg) * AW'(s1_wtl_reg) + AW'(s1_tr_reg) * AW'(s1_wtr_reg)
               + AW'(s1_bl_reg) * AW'(s1_wbl_reg) + AW'(s1_br_reg) * AW'(s1_wbr_reg);
    assign acc_shift = (acc + HALF) >> SH;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_last_reg <= in_last;
        s1_ref_reg  <= ref_pixel;
        s1_tl_reg   <= cur_top_left;
        s1_tr_reg   <= cur_top_right;
        s1_bl_reg   <= cur_bottom_left;
        s1_br_reg   <= cur_bottom_right;
        s1_wtl_reg  <= w_tl;
        s1_wtr_reg  <= w_tr;
        s1_wbl_reg  <= w_bl;
        s1_wbr_reg  <= w_br;
        s2_last_reg <= s1_last_reg;
        s2_ref_reg  <= s1_ref_reg;
        s2_c_reg    <= acc_shift[15:0];
    end

    assign c_valid = s2_valid_reg;
    assign c_value = s2_c_reg;
    assign c_ref   = s2_ref_reg;
    assign c_last  = s2_last_reg;
endmodule

/* hw/rtl/zncc_mul.sv */
// Shift-add multiplier, one multiplier bit per cycle, stops when the rest is zero.
module zncc_mul #(
    parameter int AW = 112,
    parameter int BW = 40
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [AW-1:0] a,
    input  logic [BW-1:0] b,
    output logic          done,
    output logic [AW-1:0] product
);
    logic          busy_reg, done_reg;
    logic [AW-1:0] a_reg, acc_reg;
    logic [BW-1:0] b_reg;
    logic          b_zero;

    assign b_zero = (b_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && b_zero && !start;
            busy_reg <= start || (busy_reg && !b_zero);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
        end
        else if (busy_reg && !b_zero)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule

/* hw/rtl/zncc_datapath.sv */
// Accumulators, final-score registers and output register of the ZNCC unit.
module zncc_datapath #(
    parameter int FRAC_BITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic [7:0]          ref_pixel,
    input  logic [7:0]          cur_top_left,
    input  logic [7:0]          cur_top_right,
    input  logic [7:0]          cur_bottom_left,
    input  logic [7:0]          cur_bottom_right,
    input  logic [7:0]          frac_x,
    input  logic [7:0]          frac_y,
    input  logic                in_last,
    input  zncc_pkg::dp_cmd_t   cmd,
    output zncc_pkg::dp_status_t status,
    input  logic                out_ready,
    output logic                out_valid,
    output logic signed [15:0]  score,
    output logic                flat_window
);
    import zncc_pkg::*;

    logic        c_valid, c_last;
    logic [15:0] c_value;
    logic [7:0]  c_ref;

    logic        p_valid_reg, p_last_reg;
    logic [7:0]  p_r_reg;
    logic [15:0] p_c_reg, p_rr_reg;
    logic [31:0] p_cc_reg;
    logic [23:0] p_rc_reg;

    logic [7:0]  n_reg;
    logic [15:0] sr_reg;
    logic [23:0] sc_reg, srr_reg;
    logic [39:0] scc_reg;
    logic [31:0] src_reg;
    logic        last_done_reg;

    logic [MUL_AW-1:0] x1_reg;
    logic [31:0]       vr_reg;
    logic [48:0]       vc_reg;
    logic [39:0]       mag_reg;
    logic              neg_reg;
    logic [80:0]       pv_reg;
    logic [79:0]       csq_reg;
    logic [14:0]       q_reg;

    logic              out_valid_reg, out_flat_reg;
    logic [15:0]       out_score_reg;

    logic [MUL_AW-1:0] mul_a, mul_prod;
    logic [MUL_BW-1:0] mul_b;
    logic              mul_done;
    logic [14:0]       cand, t_val;
    logic [40:0]       cov_w, cov_neg;
    logic              flat;

    zncc_interp #(.FRAC_BITS(FRAC_BITS)) u_interp (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_fire),
        .ref_pixel        (ref_pixel),
        .cur_top_left     (cur_top_left),
        .cur_top_right    (cur_top_right),
        .cur_bottom_left  (cur_bottom_left),
        .cur_bottom_right (cur_bottom_right),
        .frac_x           (frac_x),
        .frac_y           (frac_y),
        .in_last          (in_last),
        .c_valid          (c_valid),
        .c_value          (c_value),
        .c_ref            (c_ref),
        .c_last           (c_last)
    );

    zncc_mul #(.AW(MUL_AW), .BW(MUL_BW)) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    // Candidate quotient bit and its odd test value 2*cand-1.
    assign cand    = q_reg | (15'd1 << cmd.bit_idx);
    assign t_val   = {cand[13:0], 1'b0} - 15'd1;
    assign cov_w   = {1'b0, x1_reg[39:0]} - {1'b0, mul_prod[39:0]};
    assign cov_neg = 41'd0 - cov_w;
    assign flat    = (vr_reg == '0) || (vc_reg == '0);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_N_SRR:   begin mul_a = MUL_AW'(srr_reg); mul_b = MUL_BW'(n_reg);   end
            OP_SR_SR:   begin mul_a = MUL_AW'(sr_reg);  mul_b = MUL_BW'(sr_reg);  end
            OP_N_SCC:   begin mul_a = MUL_AW'(scc_reg); mul_b = MUL_BW'(n_reg);   end
            OP_SC_SC:   begin mul_a = MUL_AW'(sc_reg);  mul_b = MUL_BW'(sc_reg);  end
            OP_N_SRC:   begin mul_a = MUL_AW'(src_reg); mul_b = MUL_BW'(n_reg);   end
            OP_SR_SC:   begin mul_a = MUL_AW'(sc_reg);  mul_b = MUL_BW'(sr_reg);  end
            OP_VR_VC:   begin mul_a = MUL_AW'(vc_reg);  mul_b = MUL_BW'(vr_reg);  end
            OP_COV_COV: begin mul_a = MUL_AW'(mag_reg); mul_b = mag_reg;          end
            OP_P_T:     begin mul_a = MUL_AW'(pv_reg);  mul_b = MUL_BW'(t_val);   end
            OP_X_T:     begin mul_a = x1_reg;           mul_b = MUL_BW'(t_val);   end
            default:    begin mul_a = '0;               mul_b = '0;               end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            n_reg         <= '0;
            sr_reg        <= '0;
            sc_reg        <= '0;
            srr_reg       <= '0;
            scc_reg       <= '0;
            src_reg       <= '0;
            last_done_reg <= 1'b0;
            q_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= c_valid;
            if (cmd.clear)
            begin
                n_reg         <= '0;
                sr_reg        <= '0;
                sc_reg        <= '0;
                srr_reg       <= '0;
                scc_reg       <= '0;
                src_reg       <= '0;
                last_done_reg <= 1'b0;
            end
            else if (p_valid_reg)
            begin
                // Drop the item once the count is full; the sums stay in range.
                if (n_reg != 8'(COUNT_MAX))
                begin
                    n_reg   <= n_reg + 8'd1;
                    sr_reg  <= sr_reg + 16'(p_r_reg);
                    sc_reg  <= sc_reg + 24'(p_c_reg);
                    srr_reg <= srr_reg + 24'(p_rr_reg);
                    scc_reg <= scc_reg + 40'(p_cc_reg);
                    src_reg <= src_reg + 32'(p_rc_reg);
                end
                if (p_last_reg)
                begin
                    last_done_reg <= 1'b1;
                end
            end

            if (cmd.q_clear)
            begin
                q_reg <= '0;
            end
            else if (mul_done && cmd.op == OP_X_T &&
                     mul_prod <= {2'b00, csq_reg, 30'd0})
            begin
                q_reg <= cand;
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_last_reg <= c_last;
        p_r_reg    <= c_ref;
        p_c_reg    <= c_value;
        p_rr_reg   <= 16'(c_ref) * 16'(c_ref);
        p_cc_reg   <= 32'(c_value) * 32'(c_value);
        p_rc_reg   <= 24'(c_ref) * 24'(c_value);

        if (mul_done)
        begin
            case (cmd.op)
                OP_N_SRR, OP_N_SCC, OP_N_SRC, OP_P_T: x1_reg <= mul_prod;
                OP_SR_SR:   vr_reg  <= x1_reg[31:0] - mul_prod[31:0];
                OP_SC_SC:   vc_reg  <= x1_reg[48:0] - mul_prod[48:0];
                OP_SR_SC:
                begin
                    neg_reg <= cov_w[40];
                    mag_reg <= cov_w[40] ? cov_neg[39:0] : cov_w[39:0];
                end
                OP_VR_VC:   pv_reg  <= mul_prod[80:0];
                OP_COV_COV: csq_reg <= mul_prod[79:0];
                default:    ;
            endcase
        end

        if (cmd.out_load)
        begin
            out_flat_reg  <= flat;
            if (flat)
            begin
                out_score_reg <= '0;
            end
            else
            begin
                out_score_reg <= neg_reg ? 16'd0 - {1'b0, q_reg} : {1'b0, q_reg};
            end
        end
    end

    assign status.last_done = last_done_reg;
    assign status.mul_done  = mul_done;
    assign status.flat      = flat;
    assign status.cand_over = cand[14] && (cand[13:0] != '0);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign score       = out_score_reg;
    assign flat_window = out_flat_reg;
endmodule

/* hw/rtl/zncc_ctrl.sv */
// Sequencer for accumulation, variance and covariance products and the score search.
module zncc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_fire,
    input  logic                 in_last,
    output logic                 in_ready,
    input  zncc_pkg::dp_status_t status,
    output zncc_pkg::dp_cmd_t    cmd
);
    import zncc_pkg::*;

    typedef enum logic [2:0] {
        S_ACC,
        S_DRAIN,
        S_MUL_GO,
        S_MUL_WAIT,
        S_BIT,
        S_OUT
    } state_t;

    state_t     state_reg, state_next;
    mul_op_t    op_reg, op_next;
    logic [3:0] bit_reg, bit_next;

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        bit_next      = bit_reg;
        cmd           = '0;
        cmd.op        = op_reg;
        cmd.bit_idx   = bit_reg;
        case (state_reg)
            S_ACC:
            begin
                if (in_fire && in_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (status.last_done)
                begin
                    cmd.q_clear = 1'b1;
                    op_next     = OP_N_SRR;
                    state_next  = S_MUL_GO;
                end
            end
            S_MUL_GO:
            begin
                cmd.mul_start = 1'b1;
                state_next    = S_MUL_WAIT;
            end
            S_MUL_WAIT:
            begin
                if (status.mul_done)
                begin
                    state_next = S_MUL_GO;
                    case (op_reg)
                        OP_N_SRR:   op_next = OP_SR_SR;
                        OP_SR_SR:   op_next = OP_N_SCC;
                        OP_N_SCC:   op_next = OP_SC_SC;
                        OP_SC_SC:   op_next = OP_N_SRC;
                        OP_N_SRC:   op_next = OP_SR_SC;
                        OP_SR_SC:
                        begin
                            if (status.flat)
                            begin
                                state_next = S_OUT;
                            end
                            else
                            begin
                                op_next = OP_VR_VC;
                            end
                        end
                        OP_VR_VC:   op_next = OP_COV_COV;
                        OP_COV_COV:
                        begin
                            bit_next   = Q_MSB;
                            state_next = S_BIT;
                        end
                        OP_P_T:     op_next = OP_X_T;
                        OP_X_T:
                        begin
                            if (bit_reg == '0)
                            begin
                                state_next = S_OUT;
                            end
                            else
                            begin
                                bit_next   = bit_reg - 4'd1;
                                state_next = S_BIT;
                            end
                        end
                        default:    state_next = S_OUT;
                    endcase
                end
            end
            S_BIT:
            begin
                // Skip candidates above +1.0.
                if (status.cand_over)
                begin
                    if (bit_reg == '0)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        bit_next = bit_reg - 4'd1;
                    end
                end
                else
                begin
                    op_next    = OP_P_T;
                    state_next = S_MUL_GO;
                end
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.clear    = 1'b1;
                    state_next   = S_ACC;
                end
            end
            default:    state_next = S_ACC;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ACC;
            op_reg    <= OP_N_SRR;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            bit_reg   <= bit_next;
        end
    end

    assign in_ready = (state_reg == S_ACC);
endmodule

/* hw/rtl/zero_mean_ncc_score_unit.sv */
// Zero-mean NCC score unit: one pixel item per cycle, one score item per window.
// Throughput: one item per cycle while a window accumulates; the window ends on last.
// After last: the pipeline drains (interp s1, s2 and product registers), then shift-add
// multiplies run (one bit per cycle, flat windows stop early), then the output is loaded.
// Input stalls during that computation; a finished score waits in the output register.
// Reset (asynchronous, active low) clears sums, count, sequencer and output valid.
module zero_mean_ncc_score_unit #(
    parameter int FRAC_BITS = 8
) (
    input logic        clk,
    input logic        rst_n,
    zncc_in_if.sink    pixels,
    zncc_out_if.source result
);
    import zncc_pkg::*;

    logic       in_fire;
    logic       in_ready;
    dp_cmd_t    cmd;
    dp_status_t status;

    assign pixels.ready = in_ready;
    assign in_fire      = pixels.valid && in_ready;

    zncc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_last  (pixels.last),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    zncc_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_fire          (in_fire),
        .ref_pixel        (pixels.ref_pixel),
        .cur_top_left     (pixels.cur_top_left),
        .cur_top_right    (pixels.cur_top_right),
        .cur_bottom_left  (pixels.cur_bottom_left),
        .cur_bottom_right (pixels.cur_bottom_right),
        .frac_x           (pixels.frac_x),
        .frac_y           (pixels.frac_y),
        .in_last          (pixels.last),
        .cmd              (cmd),
        .status           (status),
        .out_ready        (result.ready),
        .out_valid        (result.valid),
        .score            (result.score),
        .flat_window      (result.flat_window)
    );
endmodule

/* hw/rtl/zncc_checker.sv */
// Port-level checks for the ZNCC score unit, bound to the top level.
module zncc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_last,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] score,
    input logic        flat_window
);
    // Hold the score item while it is stalled.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(score) && $stable(flat_window))
        else $error("score item changed while stalled");

    // Stop taking pixels once the window closes.
    a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("pixel accepted right after last");

    a_flat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && flat_window |-> score == 16'd0)
        else $error("flat window with nonzero score");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $signed(score) <= 16'sd16384 && $signed(score) >= -16'sd16384)
        else $error("score out of range");
endmodule

bind zero_mean_ncc_score_unit zncc_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (pixels.valid),
    .in_ready    (pixels.ready),
    .in_last     (pixels.last),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .score       (result.score),
    .flat_window (result.flat_window)
);

/* tb/zncc_tb_pkg.sv */
// Pixel item and score item types for the ZNCC testbench.
package zncc_tb_pkg;

    typedef struct packed {
        logic [7:0] ref_pixel;
        logic [7:0] cur_top_left;
        logic [7:0] cur_top_right;
        logic [7:0] cur_bottom_left;
        logic [7:0] cur_bottom_right;
        logic [7:0] frac_x;
        logic [7:0] frac_y;
        logic       last;
    } pixel_item_t;

    typedef struct packed {
        logic signed [15:0] score;
        logic               flat_window;
    } score_item_t;

endpackage

/* tb/testbench.sv */
// Stream testbench for the ZNCC score unit with a bit-exact score predictor.
module testbench;
    import zncc_pkg::*;
    import zncc_tb_pkg::*;

    localparam int WIN_RANDOM     = 0;
    localparam int WIN_CORRELATED = 1;
    localparam int WIN_ANTI       = 2;
    localparam int WIN_FLAT_REF   = 3;

    logic clk;
    logic rst_n;
    zncc_in_if  pixels ();
    zncc_out_if result ();

    zero_mean_ncc_score_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .pixels(pixels.sink),
        .result(result.source)
    );

    pixel_item_t pending_items[$];
    score_item_t expected_scores[$];
    int errors;
    int cycle_count;
    bit stim_done;
    int hold_off;
    int calm_start;

    // window accumulators
    logic [7:0]  win_count;
    logic [15:0] win_sum_ref;
    logic [23:0] win_sum_cur;
    logic [23:0] win_sum_ref_sq;
    logic [39:0] win_sum_cur_sq;
    logic [31:0] win_sum_cross;

    function automatic void queue_pixel(pixel_item_t p);
        pending_items.insert(pending_items.size(), p);
    endfunction

    function automatic logic [15:0] interp_current(pixel_item_t p);
        longint unsigned fx;
        longint unsigned fy;
        longint unsigned gx;
        longint unsigned gy;
        longint unsigned acc;
        fx = longint'(p.frac_x);
        fy = longint'(p.frac_y);
        gx = 256 - fx;
        gy = 256 - fy;
        acc = p.cur_top_left * gx * gy + p.cur_top_right * fx * gy
            + p.cur_bottom_left * gx * fy + p.cur_bottom_right * fx * fy;
        return 16'((acc + 128) >> 8);
    endfunction

    task automatic predict_score(pixel_item_t p);
        longint unsigned r;
        longint unsigned c;
        longint unsigned n;
        logic [127:0] vr;
        logic [127:0] vc;
        logic signed [127:0] cov;
        logic [127:0] mag;
        logic [127:0] rhs;
        logic [127:0] t;
        longint unsigned q;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        score_item_t s;
        r = p.ref_pixel;
        c = interp_current(p);
        if (win_count < COUNT_MAX)
        begin
            win_count += 1;
            win_sum_ref += 16'(r);
            win_sum_cur += 24'(c);
            win_sum_ref_sq += 24'(r * r);
            win_sum_cur_sq += 40'(c * c);
            win_sum_cross += 32'(r * c);
        end
        if (!p.last)
            return;
        n = win_count;
        vr = 128'(n * win_sum_ref_sq) - 128'(win_sum_ref) * win_sum_ref;
        vc = 128'(n * win_sum_cur_sq) - 128'(win_sum_cur) * win_sum_cur;
        cov = $signed(128'(n * win_sum_cross)) - $signed(128'(win_sum_ref) * win_sum_cur);
        if (vr == 0 || vc == 0)
        begin
            s.score = '0;
            s.flat_window = 1'b1;
        end
        else
        begin
            mag = (cov < 0) ? 128'(-cov) : 128'(cov);
            mag = mag << 15;
            rhs = mag * mag;
            q = 0;
            lo = 1;
            hi = 16384;
            while (lo <= hi)
            begin
                mid = (lo + hi) >> 1;
                t = 128'(2 * mid - 1);
                if (t * t * vr * vc <= rhs)
                begin
                    q = mid;
                    lo = mid + 1;
                end
                else
                    hi = mid - 1;
            end
            s.score = (cov < 0) ? -16'(q) : 16'(q);
            s.flat_window = 1'b0;
        end
        expected_scores.insert(expected_scores.size(), s);
        win_count = 0;
        win_sum_ref = 0;
        win_sum_cur = 0;
        win_sum_ref_sq = 0;
        win_sum_cur_sq = 0;
        win_sum_cross = 0;
    endtask

    function automatic pixel_item_t rand_pixel(bit is_last);
        pixel_item_t p;
        p = pixel_item_t'($bits(pixel_item_t)'({$urandom, $urandom}));
        p.last = is_last;
        return p;
    endfunction

    task automatic add_window(int len, int mode);
        pixel_item_t p;
        int base;
        base = $urandom_range(0, 255);
        for (int i = 0; i < len; i++)
        begin
            p = rand_pixel(i == len - 1);
            case (mode)
                WIN_CORRELATED:
                begin
                    p.cur_top_left = p.ref_pixel;
                    p.cur_top_right = p.ref_pixel;
                    p.cur_bottom_left = p.ref_pixel;
                    p.cur_bottom_right = p.ref_pixel;
                end
                WIN_ANTI:
                begin
                    p.cur_top_left = ~p.ref_pixel;
                    p.cur_top_right = ~p.ref_pixel;
                    p.cur_bottom_left = ~p.ref_pixel;
                    p.cur_bottom_right = ~p.ref_pixel;
                    p.frac_x = 0;
                    p.frac_y = 0;
                end
                WIN_FLAT_REF:
                    p.ref_pixel = 8'(base);
                default: ;
            endcase
            queue_pixel(p);
        end
    endtask

    initial
    begin
        pixel_item_t p;
        int len;
        // extremes: all zero, all max, corner offsets
        p = '0;
        queue_pixel(p);
        p = '1;
        p.last = 1'b1;
        queue_pixel(p);
        p = '1;
        p.ref_pixel = 0;
        p.frac_x = 0;
        p.frac_y = 0;
        p.last = 0;
        queue_pixel(p);
        p = '1;
        p.cur_top_left = 0;
        p.last = 1'b1;
        queue_pixel(p);
        // single-item window is flat
        queue_pixel(rand_pixel(1));
        add_window(4, WIN_CORRELATED);
        add_window(4, WIN_ANTI);
        add_window(4, WIN_FLAT_REF);
        // count full: more than 255 items before last
        add_window(300, WIN_RANDOM);
        while (pending_items.size() < 700)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(2, 12);
            add_window(len, $urandom_range(0, 5));
        end
    end

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
    end

    // drive items
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixels.valid <= 0;
            {pixels.ref_pixel, pixels.cur_top_left, pixels.cur_top_right,
             pixels.cur_bottom_left, pixels.cur_bottom_right, pixels.frac_x,
             pixels.frac_y, pixels.last} <= '0;
            win_count = 0;
            win_sum_ref = 0;
            win_sum_cur = 0;
            win_sum_ref_sq = 0;
            win_sum_cur_sq = 0;
            win_sum_cross = 0;
            stim_done <= 0;
            calm_start = $urandom_range(100, 2000);
        end
        else
        begin
            pixel_item_t p;
            if (pixels.valid && pixels.ready)
            begin
                p = pending_items.pop_front();
                predict_score(p);
            end
            if (!pixels.valid || pixels.ready)
            begin
                if (pending_items.size() > 0 &&
                    ((cycle_count > calm_start && cycle_count < calm_start + 3000) ||
                     $urandom_range(0, 99) >= 32))
                begin
                    p = pending_items[0];
                    pixels.valid <= 1;
                    {pixels.ref_pixel, pixels.cur_top_left, pixels.cur_top_right,
                     pixels.cur_bottom_left, pixels.cur_bottom_right, pixels.frac_x,
                     pixels.frac_y, pixels.last} <= p;
                end
                else
                    pixels.valid <= 0;
            end
            if (pending_items.size() == 0)
                stim_done <= 1;
        end
    end

    // long hold-off once, so scores back up and input stalls
    initial
    begin
        hold_off = 0;
        wait (cycle_count == 4000);
        hold_off = 1;
        repeat (6000) @(posedge clk);
        hold_off = 0;
    end

    // receive scores
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready <= 0;
        end
        else
        begin
            score_item_t s;
            if (result.valid && result.ready)
            begin
                if (expected_scores.size() == 0)
                begin
                    $error("unexpected score item: score %0d flat %0b",
                           result.score, result.flat_window);
                    errors++;
                end
                else
                begin
                    s = expected_scores.pop_front();
                    if (result.score !== s.score)
                    begin
                        $error("score: expected %0d, actual %0d", s.score, result.score);
                        errors++;
                    end
                    if (result.flat_window !== s.flat_window)
                    begin
                        $error("flat_window: expected %0b, actual %0b",
                               s.flat_window, result.flat_window);
                        errors++;
                    end
                end
            end
            if (hold_off != 0)
                result.ready <= 0;
            else if (cycle_count > calm_start && cycle_count < calm_start + 3000)
                result.ready <= 1;
            else
                result.ready <= ($urandom_range(0, 99) >= 32);
        end
    end

    initial
    begin
        errors = 0;
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 2000000)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        wait (stim_done === 1'b1);
        wait (expected_scores.size() == 0);
        repeat (1000) @(posedge clk);
        if (errors == 0 && expected_scores.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
